FILE: rtl/psmw_pkg.sv
// ----------------------------------------------------------------------------
// psmw_pkg
// Shared types, constants and the sine table builder for the multiphase
// sine wave generator.
// ----------------------------------------------------------------------------
`default_nettype none

package psmw_pkg;

    // configuration register widths
    localparam int unsigned WAVE_FACTOR_W = 7;
    localparam int unsigned STROKE_W      = 4;
    localparam int unsigned STEP_W        = 16;
    localparam int unsigned SHIFT_W       = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned CFG_INDEX_W   = 2;

    // configuration reset values
    localparam logic [WAVE_FACTOR_W-1:0] WAVE_FACTOR_RST = 7'd100;
    localparam logic [STROKE_W-1:0]      STROKE_RST      = 4'd5;
    localparam logic [STEP_W-1:0]        PHASE_STEP_RST  = 16'd1638;
    localparam logic [SHIFT_W-1:0]       BASE_SHIFT_RST  = 16'd5461;

    // product base_shift * wave_factor and its division by one hundred
    localparam int unsigned PROD_W  = SHIFT_W + WAVE_FACTOR_W;
    localparam int unsigned PCT_REM_W = 7;
    localparam logic [PCT_REM_W:0] PCT_DIV = 8'd100;

    // ceil(2^30 / 100): the quotient is exact for every product below 2^23
    localparam int unsigned PCT_RECIP_W     = 24;
    localparam int unsigned PCT_RECIP_SHIFT = 30;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 24'd10737419;

    // stream payload layout
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned POS_W   = 15;
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 24;

    // sine table: magnitude 0..1024, signed value
    localparam int unsigned MAG_W  = 11;
    localparam int unsigned SINE_W = 12;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVE_FACTOR   = 2'd0,
        CFG_STROKE_LENGTH = 2'd1,
        CFG_PHASE_STEP    = 2'd2,
        CFG_BASE_SHIFT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic prod_load;   // register base_shift * wave_factor
        logic quot_load;   // register the quotient by one hundred
        logic rem_load;    // register the remainder, clear offset and motor count
        logic run;         // issue motors while the pipeline advances
    } dp_cmd_t;

    typedef struct packed {
        logic last_issue;  // final motor of the tick issued this cycle
    } dp_status_t;

    // round(1024*sin(2*pi*r/2^table_bits)) for r in the first quarter,
    // Q30 Taylor series with truncated products
    function automatic logic [MAG_W-1:0] quarter_sine(int unsigned r,
                                                      int unsigned table_bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rounded;
        x = (PI_Q30 * 64'd2 * 64'(r)) >> table_bits;
        term = x;
        sum = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                default: term = term / 64'd420;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rounded = (sum * 64'd1024 + (64'd1 << 29)) >> 30;
        return rounded[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/phased_sine_motor_wave_generator.sv
// ----------------------------------------------------------------------------
// phased_sine_motor_wave_generator
// Multiphase sine synthesizer producing one position per motor per tick.
// ----------------------------------------------------------------------------
// Each accepted request with tick set yields NUM_MOTORS results, motor 0
// first, tlast on the final one. Motor i reads the sine table at phase_acc
// plus floor(i*base_shift*wave_factor/100) and returns stroke_length times
// the sine (1024 per unit). After the last motor phase_acc advances by
// phase_step. A request with tick clear is taken and produces nothing. The
// input is ready again once the last motor of a tick request is issued. The
// base_shift*wave_factor product, the reciprocal multiply that gives the
// quotient by one hundred and the remainder are registered in turn, then
// one motor per cycle, while the output is not stalled, enters a three-stage
// pipeline (phase add, table read, amplitude multiply). Results leave after
// the third stage; output stalls hold the whole pipeline.
// Configuration writes are taken at any time but belong between ticks.
`default_nettype none

module phased_sine_motor_wave_generator #(
    parameter int unsigned NUM_MOTORS      = 12,
    parameter int unsigned PHASE_BITS      = 16,
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [psmw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [psmw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // request stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [psmw_pkg::S_DATA_W-1:0]      s_tdata,   // [0] tick
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [psmw_pkg::M_DATA_W-1:0]           m_tdata,   // [3:0] motor_index,
                                                               // [18:4] position
    output logic                                    m_tlast
);

    psmw_pkg::dp_cmd_t    cmd;
    psmw_pkg::dp_status_t status;

    psmw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .tick     (s_tdata[0]),
        .cmd      (cmd),
        .status   (status)
    );

    psmw_datapath #(
        .NUM_MOTORS      (NUM_MOTORS),
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    // the flagged result belongs to the highest motor
    a_last_motor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'(NUM_MOTORS - 1)))
        else $error("tlast on a motor other than the last");

    // a stroke of at most 15 keeps the position within 15 * 1024
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[18:4]) <= 15'sd15360 &&
                      $signed(m_tdata[18:4]) >= -15'sd15360))
        else $error("position outside the table range");

    // a tick request blocks the input until its motors are issued
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[0]) |=> !s_tready)
        else $error("input ready right after a tick request");
`endif

endmodule

`default_nettype wire

FILE: rtl/psmw_sine_rom.sv
// ----------------------------------------------------------------------------
// psmw_sine_rom
// Quarter-wave sine table with quadrant folding and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psmw_sine_rom #(
    parameter int unsigned TABLE_BITS = 8
) (
    input  wire logic                                 aclk,
    input  wire logic                                 en,
    input  wire logic [TABLE_BITS-1:0]                index,
    output logic signed [psmw_pkg::SINE_W-1:0]        sine
);

    localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);

    logic [psmw_pkg::MAG_W-1:0] qtab [QUARTER+1];
    logic [1:0]                 quad;
    logic [TABLE_BITS-3:0]      rel;
    logic [TABLE_BITS-2:0]      addr;
    logic [psmw_pkg::MAG_W-1:0] mag_reg;
    logic                       neg_reg;

    for (genvar k = 0; k <= QUARTER; k++) begin : g_qtab
        assign qtab[k] = psmw_pkg::quarter_sine(k, TABLE_BITS);
    end

    assign quad = index[TABLE_BITS-1 -: 2];
    assign rel  = index[TABLE_BITS-3:0];

    // mirror the falling quadrants
    assign addr = quad[0] ? ((TABLE_BITS-1)'(QUARTER) - {1'b0, rel}) : {1'b0, rel};

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= qtab[addr];
            neg_reg <= quad[1];
        end
    end

    assign sine = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

`default_nettype wire

FILE: rtl/psmw_datapath.sv
// ----------------------------------------------------------------------------
// psmw_datapath
// Configuration registers, reciprocal divide of the motor offset step, offset
// accumulator, phase accumulator and the three-stage position pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module psmw_datapath #(
    parameter int unsigned NUM_MOTORS      = 12,
    parameter int unsigned PHASE_BITS      = 16,
    parameter int unsigned SINE_TABLE_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [psmw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [psmw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire psmw_pkg::dp_cmd_t                   cmd,
    output psmw_pkg::dp_status_t                     status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [psmw_pkg::M_DATA_W-1:0]            m_tdata,
    output logic                                     m_tlast
);

    localparam int unsigned MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int unsigned PW     = psmw_pkg::PROD_W;
    localparam int unsigned RW     = psmw_pkg::PCT_REM_W;
    localparam int unsigned QFW    = PW + psmw_pkg::PCT_RECIP_W;

    // configuration
    logic [psmw_pkg::WAVE_FACTOR_W-1:0] wave_factor_reg;
    logic [psmw_pkg::STROKE_W-1:0]      stroke_reg;
    logic [psmw_pkg::STEP_W-1:0]        phase_step_reg;
    logic [psmw_pkg::SHIFT_W-1:0]       base_shift_reg;

    // divider and offset accumulator
    logic [PW-1:0]         prod_reg;
    logic [PW-1:0]         quot_reg;
    logic [RW-1:0]         rem_reg;
    logic [QFW-1:0]        quot_full;
    logic [PW-1:0]         rem_full;
    logic [RW:0]           rsum;
    logic                  rcarry;
    logic [PHASE_BITS-1:0] off_q_reg;
    logic [RW-1:0]         off_r_reg;
    logic [MIDX_W-1:0]     mcnt_reg;
    logic                  last_motor;
    logic                  adv;
    logic                  issue;

    logic [PHASE_BITS-1:0] phase_acc_reg;

    // pipeline
    logic                       v1_reg, v2_reg, v3_reg;
    logic [PHASE_BITS-1:0]      ph1_reg;
    logic [MIDX_W-1:0]          idx1_reg, idx2_reg, idx3_reg;
    logic                       last1_reg, last2_reg, last3_reg;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    logic signed [psmw_pkg::SINE_W-1:0] sine;
    logic signed [psmw_pkg::SINE_W+psmw_pkg::STROKE_W:0] pos_full;
    logic [psmw_pkg::POS_W-1:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_factor_reg <= psmw_pkg::WAVE_FACTOR_RST;
            stroke_reg      <= psmw_pkg::STROKE_RST;
            phase_step_reg  <= psmw_pkg::PHASE_STEP_RST;
            base_shift_reg  <= psmw_pkg::BASE_SHIFT_RST;
        end else if (cfg_wr_en) begin
            case (psmw_pkg::cfg_reg_t'(cfg_index))
                psmw_pkg::CFG_WAVE_FACTOR:
                    wave_factor_reg <= cfg_wdata[psmw_pkg::WAVE_FACTOR_W-1:0];
                psmw_pkg::CFG_STROKE_LENGTH:
                    stroke_reg <= cfg_wdata[psmw_pkg::STROKE_W-1:0];
                psmw_pkg::CFG_PHASE_STEP:
                    phase_step_reg <= cfg_wdata[psmw_pkg::STEP_W-1:0];
                psmw_pkg::CFG_BASE_SHIFT:
                    base_shift_reg <= cfg_wdata[psmw_pkg::SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // divide by one hundred: reciprocal multiply, then the remainder
    assign quot_full = prod_reg * psmw_pkg::PCT_RECIP;
    assign rem_full  = prod_reg - quot_reg * PW'(psmw_pkg::PCT_DIV);

    // offset of the next motor: add quotient and remainder of one step
    assign rsum   = {1'b0, off_r_reg} + {1'b0, rem_reg};
    assign rcarry = (rsum >= psmw_pkg::PCT_DIV);

    assign adv        = !v3_reg || m_tready;
    assign issue      = cmd.run && adv;
    assign last_motor = (mcnt_reg == MIDX_W'(NUM_MOTORS - 1));
    assign status.last_issue = issue && last_motor;

    always_ff @(posedge aclk) begin
        if (cmd.prod_load) begin
            prod_reg <= PW'(base_shift_reg * wave_factor_reg);
        end
        if (cmd.quot_load) begin
            quot_reg <= PW'(quot_full >> psmw_pkg::PCT_RECIP_SHIFT);
        end
        if (cmd.rem_load) begin
            rem_reg <= rem_full[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg <= '0;
            mcnt_reg      <= '0;
        end else begin
            if (cmd.rem_load) begin
                mcnt_reg <= '0;
            end else if (issue) begin
                mcnt_reg <= last_motor ? '0 : mcnt_reg + MIDX_W'(1);
            end
            if (status.last_issue) begin
                phase_acc_reg <= phase_acc_reg + PHASE_BITS'(phase_step_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rem_load) begin
            off_q_reg <= '0;
            off_r_reg <= '0;
        end else if (issue) begin
            off_q_reg <= off_q_reg + PHASE_BITS'(quot_reg) + PHASE_BITS'(rcarry);
            off_r_reg <= rcarry ? RW'(rsum - psmw_pkg::PCT_DIV) : rsum[RW-1:0];
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage payloads
    always_ff @(posedge aclk) begin
        if (adv) begin
            ph1_reg   <= phase_acc_reg + off_q_reg;
            idx1_reg  <= mcnt_reg;
            last1_reg <= last_motor;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
            pos_reg   <= pos_full[psmw_pkg::POS_W-1:0];
        end
    end

    if (PHASE_BITS >= SINE_TABLE_BITS) begin : g_idx_trunc
        assign rom_idx = ph1_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    end else begin : g_idx_shift
        assign rom_idx = {ph1_reg, {(SINE_TABLE_BITS - PHASE_BITS){1'b0}}};
    end

    psmw_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .aclk  (aclk),
        .en    (adv),
        .index (rom_idx),
        .sine  (sine)
    );

    assign pos_full = $signed({1'b0, stroke_reg}) * sine;

    assign m_tvalid = v3_reg;
    assign m_tlast  = last3_reg;
    assign m_tdata  = {{(psmw_pkg::M_DATA_W - psmw_pkg::POS_W - psmw_pkg::IDX_W){1'b0}},
                       pos_reg, psmw_pkg::IDX_W'(idx3_reg)};

endmodule

`default_nettype wire

FILE: rtl/psmw_ctrl.sv
// ----------------------------------------------------------------------------
// psmw_ctrl
// Tick sequencer: product, quotient, remainder, then one motor per advance.
// ----------------------------------------------------------------------------
`default_nettype none

module psmw_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic                  tick,
    output psmw_pkg::dp_cmd_t          cmd,
    input  wire psmw_pkg::dp_status_t  status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_QUOT,
        ST_REM,
        ST_RUN
    } state_t;

    state_t             state_reg;
    psmw_pkg::dp_cmd_t  cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmd_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    // an idle tick is taken and dropped
                    if (s_tvalid && tick) begin
                        cmd_reg.prod_load <= 1'b1;
                        state_reg         <= ST_MULT;
                    end
                end
                ST_MULT: begin
                    cmd_reg.prod_load <= 1'b0;
                    cmd_reg.quot_load <= 1'b1;
                    state_reg         <= ST_QUOT;
                end
                ST_QUOT: begin
                    cmd_reg.quot_load <= 1'b0;
                    cmd_reg.rem_load  <= 1'b1;
                    state_reg         <= ST_REM;
                end
                ST_REM: begin
                    cmd_reg.rem_load <= 1'b0;
                    cmd_reg.run      <= 1'b1;
                    state_reg        <= ST_RUN;
                end
                ST_RUN: begin
                    if (status.last_issue) begin
                        cmd_reg.run <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    cmd_reg   <= '0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd      = cmd_reg;
    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

FILE: sim/motor_wave_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_wave_checker
// Watches the configuration port and both streams of the multiphase sine
// generator. It keeps its own copy of the registers and the phase
// accumulator, and queues the twelve motor positions that each tick request
// should produce. Each result that leaves the block is compared with the
// oldest queued position.
// ----------------------------------------------------------------------------

module motor_wave_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [psmw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [psmw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [psmw_pkg::S_DATA_W-1:0]    s_tdata,   // [0] tick
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [psmw_pkg::M_DATA_W-1:0]    m_tdata,   // [3:0] motor_index,
                                                        // [18:4] position
    input  logic                             m_tlast,
    output int unsigned                      fail_count,
    output int unsigned                      outstanding,
    output int unsigned                      positions_checked
);
    import psmw_pkg::*;

    localparam int unsigned MOTORS     = 12;
    localparam int unsigned TABLE_BITS = 8;
    localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
    localparam logic [63:0] PI_FIXED   = 64'd3373259426;  // pi in Q30

    typedef struct packed {
        logic [IDX_W-1:0] motor;
        logic [POS_W-1:0] position;
        logic             last;
    } motor_position_t;

    logic signed [11:0]        sine_lut [TABLE_SIZE];
    motor_position_t           expected_positions_q [$];

    logic [WAVE_FACTOR_W-1:0]  wave_pct;
    logic [STROKE_W-1:0]       stroke;
    logic [STEP_W-1:0]         step;
    logic [SHIFT_W-1:0]        shift;
    logic [15:0]               phase_acc;

    // first quarter of the sine, 1024 full scale, Taylor series in Q30
    function automatic logic [10:0] quarter_wave_mag(int unsigned r);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rounded;
        x = (PI_FIXED * 64'd2 * 64'(r)) >> TABLE_BITS;
        term = x;
        sum = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / (64'(2 * n) * 64'(2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        rounded = (sum * 64'd1024 + (64'd1 << 29)) >> 30;
        return rounded[10:0];
    endfunction

    initial begin
        int unsigned quad;
        int unsigned r;
        logic signed [11:0] mag;
        for (int k = 0; k < TABLE_SIZE; k++) begin
            quad = (k >> (TABLE_BITS - 2)) & 3;
            r = k & ((TABLE_SIZE / 4) - 1);
            if (quad & 1) begin
                r = TABLE_SIZE / 4 - r;
            end
            mag = $signed({1'b0, quarter_wave_mag(r)});
            sine_lut[k] = (quad & 2) ? -mag : mag;
        end
    end

    // queue the positions of one tick, then advance the accumulator
    task automatic predict_motor_positions();
        logic [63:0]        offset;
        logic [15:0]        phase;
        logic signed [15:0] pos;
        motor_position_t    item;
        for (int i = 0; i < MOTORS; i++) begin
            offset = (64'(i) * 64'(shift) * 64'(wave_pct)) / 64'd100;
            phase = phase_acc + offset[15:0];
            pos = $signed({1'b0, stroke}) * sine_lut[phase[15:8]];
            item.motor = i[IDX_W-1:0];
            item.position = pos[POS_W-1:0];
            item.last = (i == MOTORS - 1);
            expected_positions_q.push_back(item);
        end
        phase_acc = phase_acc + step;
    endtask

    task automatic compare_position();
        motor_position_t want;
        if (expected_positions_q.size() == 0) begin
            $display("%t: result with nothing expected: motor %0d position %0d last %0b",
                     $time, m_tdata[3:0], $signed(m_tdata[18:4]), m_tlast);
            fail_count++;
        end else begin
            want = expected_positions_q.pop_front();
            positions_checked++;
            if (m_tdata[3:0] !== want.motor) begin
                $display("%t: motor_index mismatch: expected %0d, actual %0d",
                         $time, want.motor, m_tdata[3:0]);
                fail_count++;
            end
            if (m_tdata[18:4] !== want.position) begin
                $display("%t: position mismatch on motor %0d: expected %0d, actual %0d",
                         $time, want.motor, $signed(want.position),
                         $signed(m_tdata[18:4]));
                fail_count++;
            end
            if (m_tlast !== want.last) begin
                $display("%t: last flag mismatch on motor %0d: expected %0b, actual %0b",
                         $time, want.motor, want.last, m_tlast);
                fail_count++;
            end
        end
    endtask

    initial begin
        fail_count = 0;
        outstanding = 0;
        positions_checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            wave_pct <= WAVE_FACTOR_RST;
            stroke <= STROKE_RST;
            step <= PHASE_STEP_RST;
            shift <= BASE_SHIFT_RST;
            phase_acc = '0;
            expected_positions_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_WAVE_FACTOR:   wave_pct <= cfg_wdata[WAVE_FACTOR_W-1:0];
                    CFG_STROKE_LENGTH: stroke <= cfg_wdata[STROKE_W-1:0];
                    CFG_PHASE_STEP:    step <= cfg_wdata[STEP_W-1:0];
                    CFG_BASE_SHIFT:    shift <= cfg_wdata[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            // idle requests are taken but produce nothing
            if (s_tvalid && s_tready && s_tdata[0]) begin
                predict_motor_positions();
            end
            if (m_tvalid && m_tready) begin
                compare_position();
            end
        end
        outstanding = expected_positions_q.size();
    end

endmodule

FILE: sim/phased_sine_motor_wave_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// phased_sine_motor_wave_generator_test
// Drives tick and idle requests into the multiphase sine generator under a
// series of register settings, with random gaps on both streams and one long
// output hold-off. The checker beside the block predicts every motor position.
// ----------------------------------------------------------------------------

module phased_sine_motor_wave_generator_test;
    import psmw_pkg::*;

    localparam int unsigned LIMIT        = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned LONG_HOLD    = 250;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 60;
    localparam int unsigned FINAL_ITEMS  = 59;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_DATA_W-1:0]     s_tdata = '0;   // [0] tick
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;        // [3:0] motor_index, [18:4] position
    logic                    m_tlast;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned positions_checked;
    int unsigned cycle_count = 0;
    int unsigned tick_requests = 0;
    int unsigned idle_requests = 0;
    int unsigned settings_used = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    bit          hold_off_req = 1'b0;

    phased_sine_motor_wave_generator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    motor_wave_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .fail_count        (fail_count),
        .outstanding       (outstanding),
        .positions_checked (positions_checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d positions outstanding",
                     cycle_count, outstanding);
            $display("phased_sine_motor_wave_generator verification failed");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_tready = 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // entered and left at a falling edge; valid stays high for the next request
    task automatic send_request(input logic tick_bit);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(S_DATA_W - 1){1'b0}}, tick_bit};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (tick_bit) begin
            tick_requests++;
        end else begin
            idle_requests++;
        end
    endtask

    // drop valid, let every position drain and an idle request settle
    task automatic wait_drained();
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t reg_sel, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = reg_sel;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] wave_pct,
                                 input logic [CFG_DATA_W-1:0] stroke,
                                 input logic [CFG_DATA_W-1:0] step,
                                 input logic [CFG_DATA_W-1:0] shift);
        wait_drained();
        write_reg(CFG_WAVE_FACTOR, wave_pct);
        write_reg(CFG_STROKE_LENGTH, stroke);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_BASE_SHIFT, shift);
        settings_used++;
    endtask

    // extremes of the register width, or any 16-bit value to exercise masking
    function automatic logic [CFG_DATA_W-1:0] pick_setting(int unsigned width);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DATA_W'((1 << width) - 1);
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // reset values, including an idle request
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        // widest offsets, wave factor above one hundred, full stroke
        load_settings(16'd127, 16'd15, 16'd65535, 16'd65535);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        // all registers at zero: flat output, frozen phase
        load_settings(16'd0, 16'd0, 16'd0, 16'd0);
        send_request(1'b1);
        send_request(1'b1);
        // upper bits beyond the register widths must be dropped
        load_settings(16'hFFE4, 16'hFFF1, 16'd1, 16'd1);
        send_request(1'b1);
        send_request(1'b1);

        for (int p = 0; p < PHASES; p++) begin
            load_settings(pick_setting(WAVE_FACTOR_W), pick_setting(STROKE_W),
                          pick_setting(STEP_W), pick_setting(SHIFT_W));
            // fill the block while the result side is held off
            if (p == 2) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_request($urandom_range(0, 7) != 0);
            end
        end

        // closing stretch at full rate on both sides
        load_settings(16'd100, CFG_DATA_W'($urandom_range(1, 10)),
                      CFG_DATA_W'($urandom_range(0, 65535)), 16'd5461);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int n = 0; n < FINAL_ITEMS; n++) begin
            send_request($urandom_range(0, 7) != 0);
        end
        s_tvalid = 1'b0;

        wait (outstanding == 0);
        repeat (60) @(posedge aclk);

        $display("Run covered %0d tick and %0d idle requests over %0d register settings,",
                 tick_requests, idle_requests, settings_used);
        $display("%0d motor positions compared, with a %0d-cycle output hold-off.",
                 positions_checked, LONG_HOLD);
        if (fail_count == 0) begin
            $display("phased_sine_motor_wave_generator verification clean");
        end else begin
            $display("phased_sine_motor_wave_generator verification failed");
        end
        $finish;
    end

endmodule
